// ===== src/vlcp_pkg.sv =====
// ----------------------------------------------------------------------------
// vlcp_pkg
// Shared widths and types of the variable-length code bit packer.
// ----------------------------------------------------------------------------
package vlcp_pkg;

    localparam int CODE_W = 24;
    localparam int LEN_W  = 5;
    localparam int BYTE_W = 8;
    localparam int CNT_W  = 6;
    localparam int ACC_W  = 32;

    // one classified code request, as held in the queue
    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  len;
        logic              flush;
    } item_t;

    // status of the back end, seen by the top level
    typedef struct packed {
        logic             emitting;
        logic [CNT_W-1:0] cnt;
    } back_stat_t;

endpackage

// ===== src/vlcp_front.sv =====
// ----------------------------------------------------------------------------
// vlcp_front
// Classifies an incoming code request: saturates the length and masks the
// code bits above it.
// ----------------------------------------------------------------------------
module vlcp_front #(
    parameter int MAX_CODE_LEN = 24
) (
    input  logic [vlcp_pkg::CODE_W-1:0] code_bits,
    input  logic [vlcp_pkg::LEN_W-1:0]  code_length,
    input  logic                        flush,
    output vlcp_pkg::item_t             item
);

    localparam int LIM = (MAX_CODE_LEN < vlcp_pkg::CODE_W) ? MAX_CODE_LEN : vlcp_pkg::CODE_W;

    logic [vlcp_pkg::LEN_W-1:0]  len_sat;
    logic [vlcp_pkg::CODE_W-1:0] code_mask;

    always_comb begin
        len_sat   = (code_length > vlcp_pkg::LEN_W'(LIM)) ? vlcp_pkg::LEN_W'(LIM) : code_length;
        // all ones when the length covers the whole field
        code_mask = ~({vlcp_pkg::CODE_W{1'b1}} << len_sat);
        item.code  = code_bits & code_mask;
        item.len   = len_sat;
        item.flush = flush;
    end

endmodule

// ===== src/vlcp_queue.sv =====
// ----------------------------------------------------------------------------
// vlcp_queue
// Two-entry queue of classified code requests between front and back end.
// ----------------------------------------------------------------------------
module vlcp_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            wr_valid,
    output logic            wr_ready,
    input  vlcp_pkg::item_t wr_item,
    output logic            rd_valid,
    input  logic            rd_ready,
    output vlcp_pkg::item_t rd_item
);

    vlcp_pkg::item_t entries_reg [2];
    logic            wr_ptr_reg;
    logic            rd_ptr_reg;
    logic [1:0]      count_reg;
    logic [1:0]      count_next;
    logic            do_wr;
    logic            do_rd;

    assign wr_ready = (count_reg != 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_item  = entries_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_comb begin
        count_next = count_reg;
        if (do_wr && !do_rd) begin
            count_next = count_reg + 2'd1;
        end else if (!do_wr && do_rd) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            count_reg <= count_next;
            if (do_wr) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_rd) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            entries_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

// ===== src/vlcp_back.sv =====
// ----------------------------------------------------------------------------
// vlcp_back
// Packer: merges a code into the bit accumulator, then emits bytes through a
// single output register, one per cycle unless blocked, plus a flush pad byte.
// ----------------------------------------------------------------------------
module vlcp_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        q_valid,
    output logic                        q_ready,
    input  vlcp_pkg::item_t             q_item,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [vlcp_pkg::BYTE_W-1:0] m_out_byte,
    output logic                        m_last,
    output vlcp_pkg::back_stat_t        stat
);

    typedef enum logic {
        ST_LOAD,
        ST_EMIT
    } state_t;

    localparam logic [vlcp_pkg::CNT_W-1:0] BYTE_CNT = vlcp_pkg::CNT_W'(vlcp_pkg::BYTE_W);

    state_t                        state_reg,  state_next;
    logic [vlcp_pkg::ACC_W-1:0]    acc_reg,    acc_next;
    logic [vlcp_pkg::CNT_W-1:0]    cnt_reg,    cnt_next;
    logic                          flush_reg,  flush_next;
    logic                          valid_reg,  valid_next;
    logic [vlcp_pkg::BYTE_W-1:0]   byte_reg,   byte_next;
    logic                          last_reg,   last_next;

    logic                          out_free;
    logic [vlcp_pkg::BYTE_W-1:0]   pend_mask;
    logic [vlcp_pkg::ACC_W-1:0]    merged;
    logic [vlcp_pkg::BYTE_W-1:0]   data_byte;
    logic [vlcp_pkg::BYTE_W-1:0]   pad_byte;

    assign out_free = !valid_reg || m_ready;
    assign q_ready  = (state_reg == ST_LOAD);

    always_comb begin
        // between items at most one byte is pending
        pend_mask = ~({vlcp_pkg::BYTE_W{1'b1}} << cnt_reg);
        merged    = ({{(vlcp_pkg::ACC_W-vlcp_pkg::BYTE_W){1'b0}}, acc_reg[7:0] & pend_mask}
                     << q_item.len)
                  | {{(vlcp_pkg::ACC_W-vlcp_pkg::CODE_W){1'b0}}, q_item.code};
        data_byte = vlcp_pkg::BYTE_W'(acc_reg >> (cnt_reg - BYTE_CNT));
        pad_byte  = acc_reg[7:0] << (BYTE_CNT - cnt_reg);
    end

    always_comb begin
        state_next = state_reg;
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        flush_next = flush_reg;
        valid_next = valid_reg && !m_ready;
        byte_next  = byte_reg;
        last_next  = last_reg;
        case (state_reg)
            ST_LOAD: begin
                if (q_valid) begin
                    acc_next   = merged;
                    cnt_next   = cnt_reg + vlcp_pkg::CNT_W'(q_item.len);
                    flush_next = q_item.flush;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (cnt_reg > BYTE_CNT) begin
                    if (out_free) begin
                        valid_next = 1'b1;
                        byte_next  = data_byte;
                        last_next  = 1'b0;
                        cnt_next   = cnt_reg - BYTE_CNT;
                    end
                end else if (flush_reg) begin
                    if (out_free) begin
                        valid_next = 1'b1;
                        byte_next  = pad_byte;
                        last_next  = 1'b1;
                        acc_next   = '0;
                        cnt_next   = '0;
                        flush_next = 1'b0;
                        state_next = ST_LOAD;
                    end
                end else begin
                    state_next = ST_LOAD;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            acc_reg   <= '0;
            cnt_reg   <= '0;
            flush_reg <= 1'b0;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            acc_reg   <= acc_next;
            cnt_reg   <= cnt_next;
            flush_reg <= flush_next;
            valid_reg <= valid_next;
        end
        byte_reg <= byte_next;
        last_reg <= last_next;
    end

    assign m_valid       = valid_reg;
    assign m_out_byte    = byte_reg;
    assign m_last        = last_reg;
    assign stat.emitting = (state_reg == ST_EMIT);
    assign stat.cnt      = cnt_reg;

endmodule

// ===== src/variable_length_code_bit_packer_top.sv =====
// An accepted code request is written into the queue; the packer merges it into
// the accumulator, and its first byte leaves through the output register on m_.
// The packer merges an item, sends its bytes and closes it with the flush byte
// or a return to load; only then does it take the next item from the queue.
// Reset: synchronous, active low; clears queue, accumulator, pending count and
// output valid, so the first stream starts empty.
// ----------------------------------------------------------------------------
// variable_length_code_bit_packer_top
// Packs right-aligned variable-length codes MSB-first into bytes.
// ----------------------------------------------------------------------------
module variable_length_code_bit_packer_top #(
    parameter int MAX_CODE_LEN = 24
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [vlcp_pkg::CODE_W-1:0] s_code_bits,
    input  logic [vlcp_pkg::LEN_W-1:0]  s_code_length,
    input  logic                        s_flush,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [vlcp_pkg::BYTE_W-1:0] m_out_byte,
    output logic                        m_last
);

    vlcp_pkg::item_t      front_item;
    vlcp_pkg::item_t      q_item;
    logic                 q_valid;
    logic                 q_ready;
    vlcp_pkg::back_stat_t stat;

    vlcp_front #(
        .MAX_CODE_LEN(MAX_CODE_LEN)
    ) u_front (
        .code_bits  (s_code_bits),
        .code_length(s_code_length),
        .flush      (s_flush),
        .item       (front_item)
    );

    vlcp_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_valid(s_valid),
        .wr_ready(s_ready),
        .wr_item (front_item),
        .rd_valid(q_valid),
        .rd_ready(q_ready),
        .rd_item (q_item)
    );

    vlcp_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_item    (q_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_out_byte(m_out_byte),
        .m_last    (m_last),
        .stat      (stat)
    );

    // pending bits never exceed one byte plus a full-length code
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.cnt <= 6'd32)
        else $error("pending count out of range");

    // between items no more than one byte stays pending
    a_idle_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        !stat.emitting |-> stat.cnt <= 6'd8)
        else $error("packer idle with more than a byte pending");

    // hold the pending count while the output register is blocked
    a_hold_blocked: assert property (@(posedge aclk) disable iff (!aresetn)
        (stat.emitting && stat.cnt > 6'd8 && m_valid && !m_ready) |=> $stable(stat.cnt))
        else $error("byte emitted while output blocked");

endmodule
